// ----- rtl/hpfs_pkg.sv -----
// hough peak finder package: sizes, register indexes, shared types
// used by every module of the hough_peak_find_suppress block
package hpfs_pkg;

  localparam int R_BINS_DEF     = 128;
  localparam int THETA_BINS_DEF = 128;
  localparam int PEAK_LIMIT     = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_W          = 9;
  localparam int IDX_W          = 7;

  localparam logic [1:0] REG_MAX_PEAKS = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_THETA_RAD = 2'd2;
  localparam logic [1:0] REG_R_RAD     = 2'd3;

  // one queued vote transaction
  typedef struct packed {
    logic [15:0] vote;
    logic        last_vote;
  } vote_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_CHECK,
    ST_SUPP,
    ST_NONE
  } back_state_t;

endpackage

// ----- rtl/hough_peak_find_suppress.sv -----
// a vote is written to the store when the back end pops it from the queue; after
// last_vote each pass scans the whole store and, if its maximum passes the
// threshold, clears the clipped rectangle bin by bin. a peak is reported when
// the next pass decides, or at the end of its own suppression when it is last.
// throughput: busy while a queued frame end waits or the 4-entry queue is full;
// the receiver cannot stall. reset restores register defaults, store not cleared.
// top level: configuration registers, front queue and back end
// depends on hpfs_pkg, hpfs_front, hpfs_back
module hough_peak_find_suppress
  import hpfs_pkg::*;
#(
  parameter int R_BINS     = R_BINS_DEF,
  parameter int THETA_BINS = THETA_BINS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_vote,
  input  logic        in_last_vote,
  output logic        out_valid,
  output logic        out_found,
  output logic [6:0]  out_peak_r,
  output logic [6:0]  out_peak_theta,
  output logic [15:0] out_peak_votes,
  output logic        out_last_peak,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [5:0] max_peaks_r;
  logic [8:0] thr_ratio_r;
  logic [6:0] t_rad_r, r_rad_r;
  logic       pop, q_valid, busy_f;
  vote_item_t q_item;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_peaks_r <= 6'd1; thr_ratio_r <= 9'd128;
      t_rad_r <= 7'd2; r_rad_r <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_PEAKS: max_peaks_r <= cfg_data[5:0];
        REG_THRESHOLD: thr_ratio_r <= cfg_data[8:0];
        REG_THETA_RAD: t_rad_r     <= cfg_data[6:0];
        REG_R_RAD:     r_rad_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign busy = busy_f;

  hpfs_front u_front (
    .clk, .rst_n, .in_start(start), .in_vote, .in_last_vote,
    .busy(busy_f), .pop, .q_valid, .q_item
  );

  hpfs_back #(.R_BINS(R_BINS), .THETA_BINS(THETA_BINS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .pop,
    .max_peaks(max_peaks_r), .threshold_ratio(thr_ratio_r),
    .theta_radius(t_rad_r), .r_radius(r_rad_r),
    .out_valid, .out_found, .out_peak_r, .out_peak_theta,
    .out_peak_votes, .out_last_peak
  );

endmodule

// ----- rtl/hpfs_front.sv -----
// front end: accepts vote transactions and queues them for the back end
// depends on hpfs_pkg
module hpfs_front
  import hpfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_start,
  input  logic [15:0] in_vote,
  input  logic       in_last_vote,
  output logic       busy,
  input  logic       pop,
  output logic       q_valid,
  output vote_item_t q_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  vote_item_t    mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          hold_r, hold_nxt;
  logic          push;

  // stop taking votes while a queued frame end waits to be popped, or while the queue is full
  assign busy    = hold_r || (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign push    = in_start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    cnt_nxt  = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    hold_nxt = hold_r;
    if (push && in_last_vote) hold_nxt = 1'b1;
    if (pop && q_item.last_vote) hold_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{vote: in_vote, last_vote: in_last_vote};
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; hold_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r  <= cnt_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

// ----- rtl/hpfs_back.sv -----
// back end: accumulator store, peak scan and neighborhood suppression
// depends on hpfs_pkg
module hpfs_back
  import hpfs_pkg::*;
#(
  parameter int R_BINS     = R_BINS_DEF,
  parameter int THETA_BINS = THETA_BINS_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  vote_item_t q_item,
  output logic       pop,
  input  logic [5:0] max_peaks,
  input  logic [8:0] threshold_ratio,
  input  logic [6:0] theta_radius,
  input  logic [6:0] r_radius,
  output logic       out_valid,
  output logic       out_found,
  output logic [6:0] out_peak_r,
  output logic [6:0] out_peak_theta,
  output logic [15:0] out_peak_votes,
  output logic       out_last_peak
);

  localparam int ACC = R_BINS * THETA_BINS;
  localparam int AW  = $clog2(ACC);
  localparam int RW  = $clog2(R_BINS);
  localparam int TW  = $clog2(THETA_BINS);
  localparam int BW  = (RW > TW) ? RW : TW;
  localparam int CW  = ((BW > 7) ? BW : 7) + 1;

  logic [15:0] acc_mem [ACC];
  logic [15:0] rd_r;

  back_state_t st_r, st_nxt;
  logic [AW-1:0] la_r;
  logic [RW-1:0] sc_r, sc_nxt;
  logic [TW-1:0] st_t_r, st_t_nxt, pt_r;
  logic          rdv_r;
  logic [RW-1:0] rr_r;
  logic [TW-1:0] rt_r;
  logic [15:0]   best_r;
  logic [RW-1:0] br_r;
  logic [TW-1:0] bt_r;
  logic [RW-1:0] pkr_r;
  logic [TW-1:0] pkt_r;
  logic [15:0]   pkv_r;
  logic [24:0]   thr_r;
  logic [5:0]    pf_r, limit;
  logic [RW-1:0] r0_r, r1_r, sr_r;
  logic [TW-1:0] t0_r, t1_r;
  logic          scan_done, rd_en, supp_end;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [15:0]   wr_data;
  logic          ok;
  logic [CW-1:0] hi_r, hi_t, lo_r, lo_t;

  assign limit = (max_peaks == 6'd0) ? 6'd1 :
                 (max_peaks > 6'(PEAK_LIMIT)) ? 6'(PEAK_LIMIT) : max_peaks;
  assign scan_done = (sc_r == RW'(R_BINS-1)) && (st_t_r == TW'(THETA_BINS-1));
  assign supp_end = (sr_r == r1_r) && (pt_r == t1_r);
  assign pop = (st_r == ST_LOAD) && q_valid;

  // peak passes the threshold test
  always_comb begin
    if (best_r == 16'd0) ok = 1'b0;
    else if (pf_r == 6'd0) ok = 1'b1;
    else ok = ({1'b0, best_r, 8'd0} >= thr_r);
  end

  // next state; the check waits while rdv_r is set so the last read joins the maximum
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD:  if (pop && q_item.last_vote) st_nxt = ST_SCAN;
      ST_SCAN:  if (scan_done) st_nxt = ST_CHECK;
      ST_CHECK: begin
        if (rdv_r) st_nxt = ST_CHECK;
        else if (!ok) st_nxt = (pf_r == 6'd0) ? ST_NONE : ST_LOAD;
        else st_nxt = ST_SUPP;
      end
      ST_SUPP: if (supp_end)
        st_nxt = (pf_r == limit) ? ST_LOAD : ST_SCAN;
      ST_NONE: st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  // memory port control and scan counters
  always_comb begin
    rd_en   = (st_r == ST_SCAN);
    rd_addr = AW'(st_t_r * R_BINS) + AW'(sc_r);
    wr_en   = 1'b0;
    wr_addr = la_r;
    wr_data = q_item.vote;
    sc_nxt  = sc_r;
    st_t_nxt = st_t_r;
    if (pop) wr_en = 1'b1;
    if (st_r == ST_SUPP) begin
      wr_en = 1'b1;
      wr_addr = AW'(pt_r * R_BINS) + AW'(sr_r);
      wr_data = 16'd0;
    end
    if (st_r == ST_SCAN) begin
      if (sc_r == RW'(R_BINS-1)) begin
        sc_nxt = '0;
        st_t_nxt = (st_t_r == TW'(THETA_BINS-1)) ? '0 : st_t_r + 1'b1;
      end else sc_nxt = sc_r + 1'b1;
    end
  end

  // clipped suppression bounds
  assign hi_r = CW'(br_r) + CW'(r_radius);
  assign hi_t = CW'(bt_r) + CW'(theta_radius);
  assign lo_r = (CW'(br_r) >= CW'(r_radius)) ? CW'(br_r) - CW'(r_radius) : '0;
  assign lo_t = (CW'(bt_r) >= CW'(theta_radius)) ? CW'(bt_r) - CW'(theta_radius) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) acc_mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= acc_mem[rd_addr];
  end

  // output strobe and fields; peak out at next pass decision or end of final clear
  always_comb begin
    out_valid = 1'b0;
    out_found = 1'b0; out_peak_r = '0; out_peak_theta = '0;
    out_peak_votes = '0; out_last_peak = 1'b0;
    if (st_r == ST_NONE) begin
      out_valid = 1'b1; out_last_peak = 1'b1;
    end else if ((st_r == ST_CHECK && !rdv_r && pf_r != 6'd0) ||
                 (st_r == ST_SUPP && supp_end && pf_r == limit)) begin
      out_valid = 1'b1; out_found = 1'b1;
      out_peak_r = 7'(pkr_r); out_peak_theta = 7'(pkt_r);
      out_peak_votes = pkv_r;
      out_last_peak = (st_r == ST_SUPP) || !ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD; la_r <= '0; sc_r <= '0; st_t_r <= '0;
      rdv_r <= 1'b0; pf_r <= '0; thr_r <= '0; best_r <= '0;
    end else begin
      st_r <= st_nxt;
      sc_r <= sc_nxt; st_t_r <= st_t_nxt;
      rdv_r <= rd_en; rr_r <= sc_r; rt_r <= st_t_r;
      if (pop) begin
        la_r <= q_item.last_vote ? '0 :
                (la_r == AW'(ACC-1)) ? '0 : la_r + 1'b1;
        if (q_item.last_vote) pf_r <= '0;
      end
      // running maximum, first in raster order wins
      if (st_r == ST_LOAD && st_nxt == ST_SCAN) best_r <= '0;
      else if (st_r == ST_CHECK && !rdv_r) best_r <= '0;
      else if (rdv_r && rd_r > best_r) begin
        best_r <= rd_r; br_r <= rr_r; bt_r <= rt_r;
      end
      if (st_r == ST_CHECK && !rdv_r && ok) begin
        if (pf_r == 6'd0) thr_r <= 25'(threshold_ratio) * 25'(best_r);
        pf_r <= pf_r + 6'd1;
        pkr_r <= br_r; pkt_r <= bt_r; pkv_r <= best_r;
        r0_r <= RW'(lo_r);
        t0_r <= TW'(lo_t);
        r1_r <= (hi_r < CW'(R_BINS)) ? RW'(hi_r) : RW'(R_BINS-1);
        t1_r <= (hi_t < CW'(THETA_BINS)) ? TW'(hi_t) : TW'(THETA_BINS-1);
        sr_r <= RW'(lo_r);
        pt_r <= TW'(lo_t);
      end
      if (st_r == ST_SUPP) begin
        if (sr_r == r1_r) begin
          sr_r <= r0_r; pt_r <= pt_r + 1'b1;
        end else sr_r <= sr_r + 1'b1;
      end
    end
  end

endmodule
